// ----- hw/rtl/mrbf_pkg.sv -----
// ----------------------------------------------------------------------------
// mrbf_pkg: shared types and constants for the motion region box finder
// Register addresses, the search sequencer's state type and the edge type.
// ----------------------------------------------------------------------------
package mrbf_pkg;

   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_COLS      = 2'd1;
   localparam logic [1:0] REG_ROWS      = 2'd2;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_SCAN,
      ST_SCAN_CHECK,
      ST_EDGE_START,
      ST_EDGE_READ,
      ST_EDGE_CHECK,
      ST_MARK,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      EDGE_LEFT,
      EDGE_TOP,
      EDGE_RIGHT,
      EDGE_BOTTOM
   } edge_type;

endpackage

// ----- hw/rtl/motion_region_box_finder.sv -----
// ----------------------------------------------------------------------------
// motion_region_box_finder: motion grid loader and region box search
// Loads per-macroblock SAD bytes into a motion map, then grows boxes around
// unsearched motion cells and reports up to MAX_REGIONS boxes.
// ----------------------------------------------------------------------------
//  channel  | ports                      | handshake
//  input    | req_sad_low, req_frame_end | start high while busy low
//  result   | rsp_box_*, rsp_regions_*   | rsp_valid, one cycle, no stall
//  config   | psel, penable, pwrite, ... | APB write at psel&penable&pwrite
//
// A record that does not end a frame leaves the block ready for the next. A
// frame_end record starts the search: a clearing pass of the searched map
// (one cell per cycle, all MAX_ROWS*MAX_COLS cells), then a raster scan of
// the grid, each cell through ST_SCAN and ST_SCAN_CHECK. Each box runs, per
// growth pass and edge, a start state and a read and a check state per edge
// cell visited, marks its cells one per cycle in ST_MARK and scans its seed
// cell again. The map memories have one read port each. busy is high for
// the whole search. Reset is synchronous and clears control and config state
// only. Results leave the registered box store one per cycle, no stall.
module motion_region_box_finder #(
   parameter int MAX_COLS    = 128,
   parameter int MAX_ROWS    = 128,
   parameter int MAX_REGIONS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_sad_low,
   input  logic       req_frame_end,
   output logic       rsp_valid,
   output logic [6:0] rsp_box_row,
   output logic [6:0] rsp_box_col,
   output logic [7:0] rsp_box_height,
   output logic [7:0] rsp_box_width,
   output logic       rsp_box_last,
   output logic       rsp_regions_dropped,
   input  logic       psel,
   input  logic       penable,
   input  logic       pwrite,
   input  logic [3:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic       pready
);
   import mrbf_pkg::*;

   localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int AB    = CB + RB;
   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int LIMC  = (MAX_COLS < 128) ? MAX_COLS : 128;
   localparam int LIMR  = (MAX_ROWS < 128) ? MAX_ROWS : 128;
   localparam int NB    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int KB    = $clog2(MAX_REGIONS + 1);

   // configuration
   logic [7:0] thr_ff, cols_ff, rows_ff;
   logic       wr_en;
   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= 8'd64;
         cols_ff <= 8'd120;
         rows_ff <= 8'd68;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            REG_THRESHOLD: thr_ff  <= pwdata[7:0];
            REG_COLS:      cols_ff <= pwdata[7:0];
            REG_ROWS:      rows_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = 32'd0;
      unique case (paddr[3:2])
         REG_THRESHOLD: prdata[7:0] = thr_ff;
         REG_COLS:      prdata[7:0] = cols_ff;
         REG_ROWS:      prdata[7:0] = rows_ff;
         default:       prdata = 32'd0;
      endcase
   end

   // clamped grid size, 1..LIMC / 1..LIMR
   logic [8:0] eff_c, eff_r;
   always_comb begin
      if (cols_ff == 8'd0) eff_c = 9'd1;
      else if ({1'b0, cols_ff} > 9'(LIMC)) eff_c = 9'(LIMC);
      else eff_c = {1'b0, cols_ff};
      if (rows_ff == 8'd0) eff_r = 9'd1;
      else if ({1'b0, rows_ff} > 9'(LIMR)) eff_r = 9'(LIMR);
      else eff_r = {1'b0, rows_ff};
   end

   // maps
   logic motion_mem [CELLS];
   logic searched_mem [CELLS];
   logic          mwe, swe, sdata;
   logic [AB-1:0] mwaddr, swaddr, mraddr, sraddr;
   logic          mwdata;
   logic          mrd_ff, srd_ff;

   always_ff @(posedge clock) begin
      if (mwe) motion_mem[mwaddr] <= mwdata;
      mrd_ff <= motion_mem[mraddr];
   end
   always_ff @(posedge clock) begin
      if (swe) searched_mem[swaddr] <= sdata;
      srd_ff <= searched_mem[sraddr];
   end

   // box result store
   logic [29:0] box_mem [MAX_REGIONS];
   logic        bwe;
   logic [NB-1:0] bwaddr, braddr;
   logic [29:0] bwdata, brd_ff;
   always_ff @(posedge clock) begin
      if (bwe) box_mem[bwaddr] <= bwdata;
      brd_ff <= box_mem[braddr];
   end

   // state
   state_type  st_ff, st_in;
   edge_type   edge_ff, edge_in;
   logic [6:0] lrow_ff, lrow_in;
   logic [7:0] lcol_ff, lcol_in;
   logic [AB:0] clr_ff, clr_in;
   logic [7:0] sr_ff, sr_in, sc_ff, sc_in;       // scan position
   logic [7:0] br_ff, br_in, bc_ff, bc_in;       // box top/left
   logic [8:0] bh_ff, bh_in, bw_ff, bw_in;       // box size
   logic [7:0] i_ff, i_in;                       // edge / mark index
   logic [7:0] j_ff, j_in;
   logic       grew_ff, grew_in;
   logic [KB-1:0] cnt_ff, cnt_in, ek_ff, ek_in;
   logic       drop_ff, drop_in;
   logic       emv_ff, emv_in;                   // emit read in flight

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_LOAD;
         lrow_ff <= '0;
         lcol_ff <= '0;
         emv_ff  <= 1'b0;
      end else begin
         st_ff   <= st_in;
         lrow_ff <= lrow_in;
         lcol_ff <= lcol_in;
         emv_ff  <= emv_in;
      end
      edge_ff <= edge_in; clr_ff <= clr_in;
      sr_ff <= sr_in; sc_ff <= sc_in; br_ff <= br_in; bc_ff <= bc_in;
      bh_ff <= bh_in; bw_ff <= bw_in; i_ff <= i_in; j_ff <= j_in;
      grew_ff <= grew_in; cnt_ff <= cnt_in; ek_ff <= ek_in;
      drop_ff <= drop_in;
   end

   function automatic logic [AB-1:0] addr_of(input logic [8:0] r, input logic [8:0] c);
      logic [17:0] a;
      a = 18'(r) * 18'(MAX_COLS) + 18'(c);
      return a[AB-1:0];
   endfunction

   logic accept;
   assign busy   = (st_ff != ST_LOAD);
   assign accept = start & ~busy;

   // edge cell coordinates (search row/col and motion row/col)
   logic [8:0] e_sr, e_sc, e_mr, e_len, e_bot, e_rgt;
   logic [8:0] e_mc;
   always_comb begin
      e_bot = {1'b0, br_ff} + bh_ff - 9'd1;
      e_rgt = {1'b0, bc_ff} + bw_ff - 9'd1;
      e_sr = 9'(br_ff); e_sc = 9'(bc_ff); e_mr = 9'(br_ff); e_mc = 9'(bc_ff);
      e_len = bh_ff;
      unique case (edge_ff)
         EDGE_LEFT: begin
            e_sr = 9'(br_ff) + 9'(i_ff); e_sc = 9'(bc_ff);
            e_mr = e_sr; e_mc = e_sc; e_len = bh_ff;
         end
         EDGE_TOP: begin
            e_sr = 9'(br_ff); e_sc = 9'(bc_ff) + 9'(i_ff);
            e_mr = e_sr; e_mc = e_sc; e_len = bw_ff;
         end
         EDGE_RIGHT: begin
            e_sr = 9'(br_ff) + 9'(i_ff); e_sc = e_rgt;
            e_mr = e_sr; e_mc = e_sc; e_len = bh_ff;
         end
         EDGE_BOTTOM: begin
            e_sr = 9'(br_ff); e_sc = 9'(bc_ff) + 9'(i_ff);
            e_mr = e_bot; e_mc = e_sc; e_len = bw_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      st_in = st_ff; edge_in = edge_ff; lrow_in = lrow_ff; lcol_in = lcol_ff;
      clr_in = clr_ff; sr_in = sr_ff; sc_in = sc_ff; br_in = br_ff; bc_in = bc_ff;
      bh_in = bh_ff; bw_in = bw_ff; i_in = i_ff; j_in = j_ff;
      grew_in = grew_ff; cnt_in = cnt_ff; ek_in = ek_ff;
      drop_in = drop_ff; emv_in = 1'b0;
      mwe = 1'b0; mwaddr = '0; mwdata = 1'b0; mraddr = '0;
      swe = 1'b0; swaddr = '0; sdata = 1'b0; sraddr = '0;
      bwe = 1'b0; bwaddr = '0; bwdata = '0; braddr = ek_ff[NB-1:0];
      rsp_valid = 1'b0;

      unique case (st_ff)
         ST_LOAD: begin
            if (accept) begin
               if ({1'b0, lcol_ff} >= eff_c) begin
                  lcol_in = '0;
                  lrow_in = lrow_ff + 7'd1;
               end else begin
                  if ({2'b0, lrow_ff} < eff_r) begin
                     mwe    = 1'b1;
                     mwaddr = addr_of({2'b0, lrow_ff}, {1'b0, lcol_ff});
                     mwdata = req_sad_low > thr_ff;
                  end
                  lcol_in = lcol_ff + 8'd1;
               end
               if (req_frame_end) begin
                  lrow_in = '0; lcol_in = '0;
                  clr_in = '0; cnt_in = '0; drop_in = 1'b0;
                  st_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            swe = 1'b1; swaddr = clr_ff[AB-1:0]; sdata = 1'b0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AB+1)'(CELLS - 1)) begin
               sr_in = '0; sc_in = '0; st_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            mraddr = addr_of(9'(sr_ff), 9'(sc_ff));
            sraddr = mraddr;
            st_in = ST_SCAN_CHECK;
         end
         ST_SCAN_CHECK: begin
            if (mrd_ff && !srd_ff) begin
               br_in = sr_ff; bc_in = sc_ff; bh_in = 9'd1; bw_in = 9'd1;
               edge_in = EDGE_LEFT; grew_in = 1'b0;
               st_in = ST_EDGE_START;
            end else if (9'(sc_ff) + 9'd1 < eff_c) begin
               sc_in = sc_ff + 8'd1; st_in = ST_SCAN;
            end else if (9'(sr_ff) + 9'd1 < eff_r) begin
               sc_in = '0; sr_in = sr_ff + 8'd1; st_in = ST_SCAN;
            end else begin
               ek_in = '0;
               st_in = (cnt_ff == '0) ? ST_LOAD : ST_EMIT;
            end
         end
         ST_EDGE_START: begin
            i_in = '0; st_in = ST_EDGE_READ;
         end
         ST_EDGE_READ: begin
            mraddr = addr_of(e_mr, e_mc);
            sraddr = addr_of(e_sr, e_sc);
            st_in = ST_EDGE_CHECK;
         end
         ST_EDGE_CHECK: begin
            if (mrd_ff && !srd_ff) begin
               // First live cell decides; the edge grows unless at the border.
               unique case (edge_ff)
                  EDGE_LEFT: if (bc_ff != 8'd0) begin
                     bc_in = bc_ff - 8'd1; bw_in = bw_ff + 9'd1; grew_in = 1'b1;
                  end
                  EDGE_TOP: if (br_ff != 8'd0) begin
                     br_in = br_ff - 8'd1; bh_in = bh_ff + 9'd1; grew_in = 1'b1;
                  end
                  EDGE_RIGHT: if (9'(bc_ff) + bw_ff < eff_c) begin
                     bw_in = bw_ff + 9'd1; grew_in = 1'b1;
                  end
                  EDGE_BOTTOM: if (9'(br_ff) + bh_ff < eff_r) begin
                     bh_in = bh_ff + 9'd1; grew_in = 1'b1;
                  end
                  default: ;
               endcase
            end
            if (mrd_ff && !srd_ff || 9'(i_ff) + 9'd1 >= e_len) begin
               if (edge_ff == EDGE_BOTTOM) begin
                  if (grew_in) begin
                     grew_in = 1'b0; edge_in = EDGE_LEFT; st_in = ST_EDGE_START;
                  end else begin
                     i_in = '0; j_in = '0; st_in = ST_MARK;
                  end
               end else begin
                  edge_in = edge_type'(edge_ff + 2'd1);
                  st_in = ST_EDGE_START;
               end
            end else begin
               i_in = i_ff + 8'd1; st_in = ST_EDGE_READ;
            end
         end
         ST_MARK: begin
            swe = 1'b1; sdata = 1'b1;
            swaddr = addr_of(9'(br_ff) + 9'(i_ff), 9'(bc_ff) + 9'(j_ff));
            if (9'(j_ff) + 9'd1 < bw_ff) begin
               j_in = j_ff + 8'd1;
            end else if (9'(i_ff) + 9'd1 < bh_ff) begin
               j_in = '0; i_in = i_ff + 8'd1;
            end else begin
               if (cnt_ff < KB'(MAX_REGIONS)) begin
                  bwe = 1'b1; bwaddr = cnt_ff[NB-1:0];
                  bwdata = {br_ff[6:0], bc_ff[6:0], bh_ff[7:0], bw_ff[7:0]};
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               // The seed cell is scanned again; it now reads as searched.
               st_in = ST_SCAN;
            end
         end
         ST_EMIT: begin
            // Box store read is registered: issue index, present next cycle.
            rsp_valid = emv_ff;
            if (ek_ff < cnt_ff) begin
               emv_in = 1'b1; ek_in = ek_ff + 1'b1; braddr = ek_ff[NB-1:0];
            end else if (!emv_ff) begin
               st_in = ST_LOAD;
            end
            if (emv_ff && ek_ff == cnt_ff) st_in = ST_LOAD;
         end
         default: st_in = ST_LOAD;
      endcase
   end

   assign rsp_box_row         = brd_ff[29:23];
   assign rsp_box_col         = brd_ff[22:16];
   assign rsp_box_height      = brd_ff[15:8];
   assign rsp_box_width       = brd_ff[7:0];
   assign rsp_box_last        = (ek_ff == cnt_ff);
   assign rsp_regions_dropped = drop_ff;

endmodule

// ----- tb/sv/tb_motion_region_box_finder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motion_region_box_finder: self-checking testbench for the box finder
// Streams frames of motion records through the command port, predicts the
// region boxes of each frame in a behavioral copy of the block and checks
// every result transfer in order. Grid size and threshold are reprogrammed
// over the APB port between frames, the extremes and clamped values included.
// ----------------------------------------------------------------------------
module tb_motion_region_box_finder;
   import mrbf_pkg::*;

   localparam int GRID_W      = 128;
   localparam int CELLS       = 128 * 128;
   localparam int REGION_CAP  = 64;
   localparam int IDLE_LIMIT  = 1500000;
   localparam int MODE_RANDOM = 0;
   localparam int MODE_SPACED = 1;
   localparam int MODE_ALL    = 2;
   localparam int MODE_NONE   = 3;
   localparam int MODE_ROWS   = 4;

   typedef struct packed {
      logic [6:0] row;
      logic [6:0] col;
      logic [7:0] height;
      logic [7:0] width;
      logic       last;
      logic       dropped;
   } box_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [7:0]  req_sad_low;
   logic        req_frame_end;
   logic        rsp_valid;
   logic [6:0]  rsp_box_row;
   logic [6:0]  rsp_box_col;
   logic [7:0]  rsp_box_height;
   logic [7:0]  rsp_box_width;
   logic        rsp_box_last;
   logic        rsp_regions_dropped;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   motion_region_box_finder dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sad_low(req_sad_low), .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid), .rsp_box_row(rsp_box_row), .rsp_box_col(rsp_box_col),
      .rsp_box_height(rsp_box_height), .rsp_box_width(rsp_box_width),
      .rsp_box_last(rsp_box_last), .rsp_regions_dropped(rsp_regions_dropped),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Behavioral copy of the block's state.
   bit          motion_bits [CELLS];
   bit          searched_bits [CELLS];
   bit          written_bits [CELLS];
   int          load_row_q;
   int          load_col_q;
   int          thresh_q;
   int          cols_q;
   int          rows_q;
   int          eff_cols;
   int          eff_rows;
   int          br, bc, bh, bw;
   box_result_type expected_boxes [$];

   int          mismatches;
   int          idle_cycles;
   int          records_sent;
   int          frames_sent;
   int          boxes_seen;
   int          overflow_frames;
   int          burst_left;
   bit          gaps_on;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int clamp_dim(int v);
      if (v < 1) return 1;
      if (v > 128) return 128;
      return v;
   endfunction

   function automatic bit live(int sr, int sc, int mr, int mc);
      return !searched_bits[sr * GRID_W + sc] && motion_bits[mr * GRID_W + mc];
   endfunction

   // Each edge test looks at the box's own edge cells, not the cells outside.
   function automatic bit extend_left();
      for (int r = br; r < br + bh; r++) begin
         if (live(r, bc, r, bc)) begin
            if (bc == 0) return 1'b0;
            bc--; bw++;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit extend_top();
      for (int c = bc; c < bc + bw; c++) begin
         if (live(br, c, br, c)) begin
            if (br == 0) return 1'b0;
            br--; bh++;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit extend_right();
      int e;
      e = bc + bw - 1;
      for (int r = br; r < br + bh; r++) begin
         if (live(r, e, r, e)) begin
            if (bc + bw >= eff_cols) return 1'b0;
            bw++;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // The bottom test pairs motion in the bottom row with the top row's searched bit.
   function automatic bit extend_bottom();
      int e;
      e = br + bh - 1;
      for (int c = bc; c < bc + bw; c++) begin
         if (live(br, c, e, c)) begin
            if (br + bh >= eff_rows) return 1'b0;
            bh++;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic find_boxes();
      box_result_type found [REGION_CAP];
      box_result_type b;
      int          count;
      bit          dropped;
      bit          grew;
      count = 0;
      dropped = 1'b0;
      foreach (searched_bits[i]) searched_bits[i] = 1'b0;
      for (int r = 0; r < eff_rows; r++) begin
         for (int c = 0; c < eff_cols; c++) begin
            if (searched_bits[r * GRID_W + c] || !motion_bits[r * GRID_W + c]) continue;
            br = r; bc = c; bh = 1; bw = 1;
            grew = 1'b1;
            while (grew) begin
               grew = 1'b0;
               if (extend_left()) grew = 1'b1;
               if (extend_top()) grew = 1'b1;
               if (extend_right()) grew = 1'b1;
               if (extend_bottom()) grew = 1'b1;
            end
            for (int i = br; i < br + bh; i++)
               for (int j = bc; j < bc + bw; j++)
                  searched_bits[i * GRID_W + j] = 1'b1;
            if (count < REGION_CAP) begin
               b.row = br[6:0]; b.col = bc[6:0];
               b.height = bh[7:0]; b.width = bw[7:0];
               b.last = 1'b0; b.dropped = 1'b0;
               found[count] = b;
               count++;
            end else begin
               dropped = 1'b1;
            end
         end
      end
      if (dropped) overflow_frames++;
      for (int k = 0; k < count; k++) begin
         b = found[k];
         b.last = (k + 1 == count);
         b.dropped = dropped;
         expected_boxes = {expected_boxes, b};
      end
   endtask

   task automatic predict_record(logic [7:0] sad, logic fend);
      eff_cols = clamp_dim(cols_q);
      eff_rows = clamp_dim(rows_q);
      if (load_col_q >= eff_cols) begin
         load_col_q = 0;
         load_row_q = (load_row_q + 1) & 127;
      end else begin
         if (load_row_q < eff_rows) begin
            motion_bits[load_row_q * GRID_W + load_col_q] = (sad > thresh_q);
            written_bits[load_row_q * GRID_W + load_col_q] = 1'b1;
         end
         load_col_q = (load_col_q + 1) & 255;
      end
      if (fend) begin
         find_boxes();
         load_row_q = 0;
         load_col_q = 0;
         frames_sent++;
      end
   endtask

   // Result checker and idle watchdog.
   always @(posedge clock) begin
      box_result_type got;
      box_result_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("** motion_region_box_finder: FAILED **");
            $finish;
         end
         if (rsp_valid) begin
            got = {rsp_box_row, rsp_box_col, rsp_box_height, rsp_box_width,
                   rsp_box_last, rsp_regions_dropped};
            boxes_seen++;
            if (expected_boxes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected box row=%0d col=%0d h=%0d w=%0d last=%0b drop=%0b",
                           got.row, got.col, got.height, got.width, got.last, got.dropped);
            end else begin
               want = expected_boxes.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"box mismatch: expected row=%0d col=%0d h=%0d w=%0d ",
                               "last=%0b drop=%0b, got row=%0d col=%0d h=%0d w=%0d ",
                               "last=%0b drop=%0b"},
                              want.row, want.col, want.height, want.width, want.last,
                              want.dropped, got.row, got.col, got.height, got.width,
                              got.last, got.dropped);
               end
            end
         end
      end
   end

   task automatic csr_write(logic [1:0] index, int value);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = {index, 2'b00};
      pwdata = {$urandom_range(0, 1) ? $urandom() : 32'd0};
      pwdata[7:0] = value[7:0];
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      case (index)
         REG_THRESHOLD: thresh_q = value & 255;
         REG_COLS:      cols_q = value & 255;
         REG_ROWS:      rows_q = value & 255;
         default: ;
      endcase
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   // Holds the sender until the search is over and every box has arrived.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      repeat (4) @(posedge clock);
      while (busy || expected_boxes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_grid(int thr, int cols, int rows);
      drain();
      csr_write(REG_THRESHOLD, thr);
      csr_write(REG_COLS, cols);
      csr_write(REG_ROWS, rows);
   endtask

   task automatic send_record(logic [7:0] sad, logic fend);
      if (gaps_on) begin
         if (burst_left == 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = $urandom_range(1, 20);
         end
         burst_left--;
      end
      @(negedge clock);
      start = 1'b1;
      req_sad_low = sad;
      req_frame_end = fend;
      do @(posedge clock); while (busy);
      predict_record(sad, fend);
      records_sent++;
   endtask

   function automatic logic [7:0] pick_sad(bit moving);
      if (moving && thresh_q < 255) return 8'($urandom_range(thresh_q + 1, 255));
      if (!moving) return 8'($urandom_range(0, thresh_q));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic bit grid_written();
      for (int r = 0; r < clamp_dim(rows_q); r++)
         for (int c = 0; c < clamp_dim(cols_q); c++)
            if (!written_bits[r * GRID_W + c]) return 1'b0;
      return 1'b1;
   endfunction

   // One frame in raster order; a short or overlong frame is sent only when
   // every grid cell already holds a written motion bit.
   task automatic run_frame(int mode, int density, bit odd_length);
      int  ec, er, total, extra, fend_at, idx, c;
      bit  moving;
      ec = clamp_dim(cols_q);
      er = clamp_dim(rows_q);
      total = er * (ec + 1);
      extra = 0;
      fend_at = total - 1;
      if (odd_length && grid_written()) begin
         if ($urandom_range(0, 1)) fend_at = $urandom_range(0, total - 1);
         else begin
            extra = $urandom_range(1, 2 * (ec + 1));
            fend_at = total + extra - 1;
         end
      end
      for (idx = 0; idx <= fend_at; idx++) begin
         c = idx % (ec + 1);
         case (mode)
            MODE_SPACED: moving = ((idx / (ec + 1)) % 3 == 1) && (c % 3 == 1);
            MODE_ROWS:   moving = ((idx / (ec + 1)) % 2 == 0) && (c % 2 == 0);
            MODE_ALL:    moving = 1'b1;
            MODE_NONE:   moving = 1'b0;
            default:     moving = ($urandom_range(0, 99) < density);
         endcase
         if (c == ec || idx >= total || (mode == MODE_RANDOM && $urandom_range(0, 9) == 0))
            send_record(8'($urandom_range(0, 255)), idx == fend_at);
         else
            send_record(pick_sad(moving), idx == fend_at);
      end
   endtask

   task automatic test_threshold_edges();
      // Grid registers of zero clamp to a single cell.
      program_grid(0, 0, 0);
      run_frame(MODE_NONE, 0, 1'b0);
      send_record(8'd1, 1'b0);
      send_record(8'd255, 1'b1);
      program_grid(255, 0, 0);
      send_record(8'd255, 1'b0);
      send_record(8'd0, 1'b1);
      program_grid(127, 1, 1);
      send_record(8'd127, 1'b0);
      send_record(8'd0, 1'b1);
      send_record(8'd128, 1'b0);
      send_record(8'd255, 1'b1);
   endtask

   task automatic test_small_boxes();
      program_grid(64, 3, 2);
      run_frame(MODE_ALL, 0, 1'b0);
      run_frame(MODE_RANDOM, 40, 1'b1);
   endtask

   task automatic test_random_frames();
      int target;
      target = records_sent + 60;
      while (records_sent < target) begin
         gaps_on = ($urandom_range(0, 9) < 7);
         if ($urandom_range(0, 1))
            program_grid($urandom_range(0, 3) == 0 ? 255 * $urandom_range(0, 1)
                                                   : $urandom_range(0, 255),
                         $urandom_range(0, 7) == 0 ? $urandom_range(9, 16)
                                                   : $urandom_range(1, 8),
                         $urandom_range(1, 4));
         if ($urandom_range(0, 9) == 0) run_frame(MODE_SPACED, 0, 1'b1);
         else run_frame(MODE_RANDOM, $urandom_range(5, 60), $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic test_largest_grid();
      // A column count of 200 clamps to 128; motion on every other cell of
      // rows 0 and 2 seeds 128 boxes, more than the region limit.
      gaps_on = 1'b0;
      program_grid(100, 200, 3);
      run_frame(MODE_ROWS, 0, 1'b0);
      gaps_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_sad_low = 8'd0;
      req_frame_end = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      paddr = 4'd0; pwdata = 32'd0;
      mismatches = 0; idle_cycles = 0; records_sent = 0; frames_sent = 0;
      boxes_seen = 0; overflow_frames = 0; burst_left = 0; gaps_on = 1'b1;
      load_row_q = 0; load_col_q = 0;
      thresh_q = 64; cols_q = 120; rows_q = 68;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_threshold_edges();
      test_small_boxes();
      test_random_frames();
      test_largest_grid();

      drain();
      repeat (100) @(posedge clock);
      if (expected_boxes.size() != 0) mismatches++;
      $display("Sent %0d records in %0d frames; checked %0d boxes, %0d frames overflowed.",
               records_sent, frames_sent, boxes_seen, overflow_frames);
      if (mismatches == 0)
         $display("** motion_region_box_finder: PASSED **");
      else
         $display("** motion_region_box_finder: FAILED **");
      $finish;
   end

endmodule
